// ===== sv/tccw_pkg.sv =====
// shared types and constants of the text console cell writer
package tccw_pkg;

  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int COLOR_W    = 4;
  localparam int CELL_W     = ATTR_W + CHAR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [CELL_W-1:0]     BLANK_CELL   = 16'h0F20;
  localparam logic [CHAR_W-1:0]     NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]     NUL_CODE     = 8'd0;
  localparam logic [COLOR_W-1:0]    FG_RESET     = 4'd2;
  localparam logic [COLOR_W-1:0]    BG_RESET     = 4'd8;

  localparam logic                  KIND_WRITE   = 1'b0;
  localparam logic                  KIND_READ    = 1'b1;

  localparam logic [CFG_IDX_W-1:0]  REG_FG_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_BG_COLOR = 1'd1;

  typedef struct packed {
    logic                 kind;
    logic [CHAR_W-1:0]    char_code;
    logic [INDEX_W-1:0]   cell_index;
  } cmd_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]   cursor_pos;
    logic [CHAR_W-1:0]    read_char;
    logic [ATTR_W-1:0]    read_attr;
  } rsp_item_t;

endpackage

// ===== sv/tccw_if.sv =====
// valid/ready channel interfaces for commands and responses
interface tccw_cmd_if import tccw_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccw_rsp_if import tccw_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tccw_cell_ram.sv =====
// single-port-write, single-port-read cell memory with registered read data
module tccw_cell_ram import tccw_pkg::*; #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/text_console_cell_writer.sv =====
// text console cell writer top level: cell store, cursor and command sequencer
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  cfg      | in  | cfg_wen (no wait)| cfg_addr (0 fg_color, 1 bg_color), cfg_wdata
//  cmd      | in  | valid / ready    | kind, char_code, cell_index
//  rsp      | out | valid / ready    | cursor_pos, read_char, read_attr
//
// one response transaction per command transaction, in order
// newline and screen-full wrap blank their cells one at a time through the single
//   memory write port
// after reset a clearing pass writes all COLUMNS*ROWS cells, cmd.ready low meanwhile
// a new command is taken while the previous response still waits in the output register
// cursor and column counter travel together, so no division is needed for rows
module text_console_cell_writer import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tccw_cmd_if.sink              cmd,
  tccw_rsp_if.source            rsp
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(COLUMNS - 1);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,  // clearing pass after reset
    S_IDLE  = 6'b000010,  // waiting for a command
    S_READ  = 6'b000100,  // memory read data arrives
    S_LINE  = 6'b001000,  // blanking rest of the row for a newline
    S_CLEAR = 6'b010000,  // blanking the whole screen on wrap
    S_EMIT  = 6'b100000   // handing the result to the output register
  } state_t;

  state_t state;

  // cursor doubles as the sweep address of every clearing pass
  logic [ADDR_W-1:0] cursor;
  logic [COL_W-1:0]  col;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              out_valid;
  rsp_item_t         out_data;

  logic              mem_we;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [CELL_W-1:0] mem_rdata;

  logic cmd_fire;
  logic read_ok;
  logic is_print;
  logic emit_go;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign read_ok   = 32'(cmd.data.cell_index) < 32'(CELLS);
  assign is_print  = (cmd.data.char_code != NUL_CODE) &&
                     (cmd.data.char_code != NEWLINE_CODE);
  // result leaves once the output register is free or being emptied
  assign emit_go   = (state == S_EMIT) && (!out_valid || rsp.ready);

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // memory port control: writes always go to the cursor, reads only on a read command;
  // the sequencer never reads and writes in the same cycle, so no forwarding is needed
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = BLANK_CELL;
    mem_re    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire && cmd.data.kind == KIND_WRITE && is_print) begin
          mem_we    = 1'b1;
          mem_wdata = {fg_color, bg_color, cmd.data.char_code};
        end
        if (cmd_fire && cmd.data.kind == KIND_READ && read_ok) begin
          mem_re = 1'b1;
        end
      end
      S_INIT, S_LINE, S_CLEAR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tccw_cell_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cursor),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (ADDR_W'(cmd.data.cell_index)),
    .rdata (mem_rdata)
  );

  // control state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cursor    <= '0;
      col       <= '0;
      out_valid <= 1'b0;
      fg_color  <= FG_RESET;
      bg_color  <= BG_RESET;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_addr)
          REG_FG_COLOR: fg_color <= cfg_wdata;
          REG_BG_COLOR: bg_color <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // a new result replaces one that leaves in the same cycle
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          if (cursor == LAST_CELL) begin
            cursor <= '0;
            state  <= S_IDLE;
          end else begin
            cursor <= cursor + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_fire) begin
            if (cmd.data.kind == KIND_READ) begin
              // out-of-range reads skip the memory and return zeros
              state <= read_ok ? S_READ : S_EMIT;
            end else if (cmd.data.char_code == NEWLINE_CODE) begin
              if (cursor >= LAST_ROW_START) begin
                // newline on the last row wraps the screen
                cursor <= '0;
                col    <= '0;
                state  <= S_CLEAR;
              end else begin
                state <= S_LINE;
              end
            end else if (is_print) begin
              if (cursor == LAST_CELL) begin
                cursor <= '0;
                col    <= '0;
                state  <= S_CLEAR;
              end else begin
                cursor <= cursor + 1'b1;
                col    <= (col == LAST_COL) ? '0 : col + 1'b1;
                state  <= S_EMIT;
              end
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_LINE: begin
          cursor <= cursor + 1'b1;
          if (col == LAST_COL) begin
            col   <= '0;
            state <= S_EMIT;
          end else begin
            col <= col + 1'b1;
          end
        end
        S_CLEAR: begin
          if (cursor == LAST_CELL) begin
            cursor <= '0;
            state  <= S_EMIT;
          end else begin
            cursor <= cursor + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res_char <= '0;
      res_attr <= '0;
    end
    if (state == S_READ) begin
      res_char <= mem_rdata[CHAR_W-1:0];
      res_attr <= mem_rdata[CELL_W-1:CHAR_W];
    end
    if (emit_go) begin
      out_data.cursor_pos <= INDEX_W'(cursor);
      out_data.read_char  <= res_char;
      out_data.read_attr  <= res_attr;
    end
  end

endmodule

// ===== sv/tccw_checker.sv =====
// port-level checks of the text console cell writer and their bind
module tccw_checker import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_item_t rsp_data
);

  localparam int CELLS = COLUMNS * ROWS;

  // a pending response is not dropped
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // a pending response does not change
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("response changed while stalled");

  // clearing pass blocks commands right after reset
  a_init_block: assert property (@(posedge clk)
    $fell(rst) |-> !cmd_ready)
    else $error("command accepted during clearing pass");

  // each command occupies the sequencer beyond its accept cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second command accepted back to back");

  // reported cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp_data.cursor_pos) < CELLS) || (CELLS > 2048))
    else $error("cursor beyond screen");

endmodule

bind text_console_cell_writer tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ===== test/tb.sv =====
// self-checking testbench for the text console cell writer
`timescale 1ns / 1ps

module tb;
  import tccw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int LAST_ROW    = CELLS - COLUMNS;
  localparam int ITEM_TARGET = 320;     // directed plus about 300 random
  localparam int HOLD_CYCLES = 400;     // long response back-pressure stretch
  localparam int DRAIN_WAIT  = 2 * COLUMNS + 20;
  localparam int CYCLE_LIMIT = 5000000; // every item a full-screen wrap under long stalls

  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration write port, idle from time zero
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tccw_cmd_if cmd_ch ();
  tccw_rsp_if rsp_ch ();

  text_console_cell_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // console shadow: screen contents, cursor and colors as the block should hold
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0]  screen [CELLS];
  int unsigned        caret;
  logic [COLOR_W-1:0] fg_nibble;
  logic [COLOR_W-1:0] bg_nibble;

  rsp_item_t  expected_replies [$];   // one per accepted command, oldest first
  cmd_item_t  cmd_backlog [$];        // commands waiting for the driver
  int         mismatches = 0;
  int         items_queued = 0;       // commands that do something (NUL excluded)

  // knobs the stimulus process turns per phase
  bit         gaps_on   = 1'b1;
  bit         stalls_on = 1'b1;
  int         hold_requests = 0;

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
  endfunction

  // advance the shadow by one accepted command and queue the reply it owes
  task automatic update_console(input cmd_item_t c);
    rsp_item_t   r;
    int unsigned next_row;
    r = '0;
    if (c.kind == KIND_READ) begin
      // out-of-range reads come back as zero
      if (c.cell_index < CELLS) begin
        r.read_char = screen[c.cell_index][CHAR_W-1:0];
        r.read_attr = screen[c.cell_index][CELL_W-1:CHAR_W];
      end
    end else if (c.char_code == NEWLINE_CODE) begin
      next_row = (caret / COLUMNS + 1) * COLUMNS;
      if (next_row >= CELLS) begin
        // newline on the last row wipes the whole screen
        blank_screen();
        caret = 0;
      end else begin
        for (int unsigned i = caret; i < next_row; i++) screen[i] = BLANK_CELL;
        caret = next_row;
      end
    end else if (c.char_code != NUL_CODE) begin
      screen[caret] = {fg_nibble, bg_nibble, c.char_code};
      caret++;
      if (caret >= CELLS) begin
        blank_screen();
        caret = 0;
      end
    end
    r.cursor_pos = caret[INDEX_W-1:0];
    expected_replies.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // mostly back-to-back, sometimes a short gap, now and then a long gap
  function automatic int idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one command transaction at a time from the backlog
  // ---------------------------------------------------------------------------
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      gap_left     <= 0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      // previous transaction accepted (or none offered): gap, next item or idle
      if (gap_left > 0) begin
        gap_left     <= gap_left - 1;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cmd_ch.data  <= cmd_backlog.pop_front();
        cmd_ch.valid <= 1'b1;
        gap_left     <= gaps_on ? idle_length() : 0;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response side: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int stall_left;
  int hold_left;
  int holds_served;
  int stall_len;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      stall_len = stalls_on ? idle_length() : 0;
      if (stall_len > 0) begin
        stall_left   <= stall_len - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each command transaction, check each response transaction
  // ---------------------------------------------------------------------------
  rsp_item_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) update_console(cmd_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("response with nothing outstanding, cursor_pos",
                          rsp_ch.data.cursor_pos, -1);
        end else begin
          want = expected_replies.pop_front();
          if (rsp_ch.data.cursor_pos !== want.cursor_pos)
            report_mismatch("cursor_pos", rsp_ch.data.cursor_pos, want.cursor_pos);
          if (rsp_ch.data.read_char !== want.read_char)
            report_mismatch("read_char", rsp_ch.data.read_char, want.read_char);
          if (rsp_ch.data.read_attr !== want.read_attr)
            report_mismatch("read_attr", rsp_ch.data.read_attr, want.read_attr);
        end
      end
    end
  end

  // watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers (called at the falling edge, away from the driver)
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(input logic kind, input int code, input int idx);
    cmd_item_t c;
    c.kind       = kind;
    c.char_code  = code[CHAR_W-1:0];
    c.cell_index = idx[INDEX_W-1:0];
    cmd_backlog.push_back(c);
    if (kind == KIND_READ || c.char_code != NUL_CODE) items_queued++;
  endfunction

  // any byte that gets stored: not NUL, not newline
  function automatic int random_glyph();
    int code;
    do code = $urandom_range(1, 255); while (code == NEWLINE_CODE);
    return code;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || expected_replies.size() != 0);
  endtask

  // register write while nothing is in flight; shadow colors follow at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == REG_FG_COLOR) fg_nibble = val;
    else bg_nibble = val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // walk the cursor to the start of the last row, then fill it until the
  // screen wraps, either by running off the end or by a newline on that row
  task automatic fill_screen(input bit end_with_newline);
    int steps;
    int count;
    int printed;
    int row;
    row = caret / COLUMNS;
    if (row < ROWS - 1) steps = ROWS - 1 - row;
    else steps = (caret == LAST_ROW) ? 0 : ROWS;
    for (int i = 0; i < steps; i++) queue_cmd(KIND_WRITE, NEWLINE_CODE, $urandom_range(0, 2047));
    count   = end_with_newline ? $urandom_range(0, COLUMNS - 1) : COLUMNS;
    printed = 0;
    while (printed < count) begin
      // sprinkle reads of the row being written and ignored NULs
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 3) == 0) queue_cmd(KIND_WRITE, NUL_CODE, $urandom_range(0, 2047));
        else queue_cmd(KIND_READ, $urandom_range(0, 255), $urandom_range(LAST_ROW, CELLS - 1));
      end else begin
        queue_cmd(KIND_WRITE, random_glyph(), $urandom_range(0, 2047));
        printed++;
      end
    end
    if (end_with_newline) queue_cmd(KIND_WRITE, NEWLINE_CODE, $urandom_range(0, 2047));
    // after the wrap every cell should read back blank
    queue_cmd(KIND_READ, $urandom_range(0, 255), LAST_ROW);
    queue_cmd(KIND_READ, $urandom_range(0, 255), CELLS - 1);
    queue_cmd(KIND_READ, $urandom_range(0, 255), $urandom_range(0, CELLS - 1));
  endtask

  // general mix of writes, newlines, NULs and reads
  task automatic mixed_batch(input int length);
    int roll;
    int idx;
    for (int i = 0; i < length; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        queue_cmd(KIND_WRITE, random_glyph(), $urandom_range(0, 2047));
      end else if (roll < 52) begin
        queue_cmd(KIND_WRITE, NEWLINE_CODE, $urandom_range(0, 2047));
      end else if (roll < 57) begin
        queue_cmd(KIND_WRITE, NUL_CODE, $urandom_range(0, 2047));
      end else begin
        // half the reads land near the cursor where the fresh cells are
        if ($urandom_range(0, 1)) begin
          idx = $urandom_range(0, 2047);
        end else begin
          idx = int'(caret) + $urandom_range(0, 40) - 30;
          if (idx < 0) idx = 0;
        end
        queue_cmd(KIND_READ, $urandom_range(0, 255), idx);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  int phase;
  int flavor;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rsp_ch.ready = 1'b0;

    blank_screen();
    caret     = 0;
    fg_nibble = FG_RESET;
    bg_nibble = BG_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, reset colors (attribute 0x28)
    queue_cmd(KIND_READ,  0,            0);       // blank cell after reset
    queue_cmd(KIND_READ,  0,            CELLS - 1);
    queue_cmd(KIND_READ,  0,            CELLS);   // first index past the screen
    queue_cmd(KIND_READ,  8'hFF,        2047);    // largest index
    queue_cmd(KIND_WRITE, 8'h41,        2047);    // index ignored on writes
    queue_cmd(KIND_WRITE, NUL_CODE,     5);       // ignored byte
    queue_cmd(KIND_WRITE, 8'hFF,        0);
    queue_cmd(KIND_WRITE, 8'h01,        0);
    queue_cmd(KIND_READ,  0,            0);
    queue_cmd(KIND_READ,  8'h00,        2);
    queue_cmd(KIND_READ,  NEWLINE_CODE, 1);       // code ignored on reads
    queue_cmd(KIND_WRITE, NEWLINE_CODE, 0);       // clears rest of row 0
    queue_cmd(KIND_READ,  0,            3);
    queue_cmd(KIND_READ,  0,            COLUMNS - 1);
    queue_cmd(KIND_WRITE, NEWLINE_CODE, 0);       // newline from column 0
    queue_cmd(KIND_WRITE, 8'h80,        0);
    queue_cmd(KIND_WRITE, 8'h7F,        11'h555);
    queue_cmd(KIND_WRITE, 8'h20,        11'h2AA);
    queue_cmd(KIND_READ,  0,            2 * COLUMNS);
    queue_cmd(KIND_READ,  0,            2 * COLUMNS + 1);
    queue_cmd(KIND_WRITE, NEWLINE_CODE, 0);
    queue_cmd(KIND_READ,  0,            2 * COLUMNS + 2);

    // random phases, each started from an idle block
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(REG_FG_COLOR, 4'hF);
          write_reg(REG_BG_COLOR, 4'h0);
        end
        1: begin
          write_reg(REG_FG_COLOR, 4'h0);
          write_reg(REG_BG_COLOR, 4'hF);
        end
        default: begin
          if ($urandom_range(0, 1)) write_reg(REG_FG_COLOR, COLOR_W'($urandom_range(0, 15)));
          if ($urandom_range(0, 1)) write_reg(REG_BG_COLOR, COLOR_W'($urandom_range(0, 15)));
        end
      endcase

      // some phases run without any idling on one side or both
      gaps_on   = (phase % 3 != 2);
      stalls_on = (phase % 4 != 3);

      if (phase == 2) begin
        // back-pressure: responses held while commands keep coming
        gaps_on = 1'b0;
        hold_requests++;
        mixed_batch(40);
      end else begin
        flavor = (phase < 2) ? phase : $urandom_range(0, 3);
        if (flavor < 2) fill_screen(flavor == 1);
        else mixed_batch(30);
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
